[rtl/ctd_pkg.sv]
// Package with shared types and constants of the CBOR transaction decoder.
package ctd_pkg;
    localparam logic [4:0] PH_MAP = 5'd0;
    localparam logic [4:0] PH_KEY = 5'd1;
    localparam logic [4:0] PH_VAL = 5'd2;
    localparam logic [4:0] PH_PARENT = 5'd3;
    localparam logic [4:0] PH_ARG = 5'd4;
    localparam logic [4:0] PH_STRING = 5'd8;
    localparam logic [4:0] PH_TRAIL = 5'd9;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_SIZE = 2'd2;

    localparam logic [1:0] REG_TRANSFER = 2'd0;
    localparam logic [1:0] REG_MINT = 2'd1;
    localparam logic [1:0] REG_CLAIM = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  field_key;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        done_res;
        logic [1:0]  status;
        logic [7:0]  tx_type;
        logic [31:0] amount;
        logic [31:0] sequence_res;
        logic [31:0] fee;
        logic [31:0] currency;
        logic [63:0] timestamp;
        logic [3:0]  parent_total;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_item;
endpackage

[rtl/ctd_if.sv]
// Valid/ready stream interface used by every channel of the decoder.
interface ctd_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/ctd_parser.sv]
// Byte parser holding the frame state and producing one result per byte.
module ctd_parser
    import ctd_pkg::*;
#(
    parameter int ACCOUNT_BYTES = 16,
    parameter int PARENT_BYTES = 32,
    parameter int MAX_PARENTS = 8,
    parameter int ID_BYTES = 32,
    parameter int SIGNATURE_BYTES = 64,
    parameter int PUBKEY_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  logic [7:0] i_code_transfer,
    input  logic [7:0] i_code_mint,
    input  logic [7:0] i_code_claim,
    output t_out_item o_result
);
    localparam int AW = (ACCOUNT_BYTES > 1) ? $clog2(ACCOUNT_BYTES) : 1;

    logic [4:0]  r_phase, n_phase;
    logic [3:0]  r_entries, n_entries;
    logic [12:0] r_seen, n_seen;
    logic [3:0]  r_key, n_key;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_hleft, n_hleft;
    logic [7:0]  r_sleft, n_sleft;
    logic [3:0]  r_pleft, n_pleft;
    logic [3:0]  r_pcount, n_pcount;
    logic [7:0]  r_soff, n_soff;
    logic        r_aeq, n_aeq;
    logic [4:0]  r_nz, n_nz;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_amt, n_amt, r_seq, n_seq, r_fee, n_fee, r_cur, n_cur;
    logic [63:0] r_ts, n_ts;
    logic [1:0]  r_err, n_err;
    logic [7:0]  r_acct [ACCOUNT_BYTES];
    logic        acct_we;
    logic [AW-1:0] acct_idx;
    t_out_item   res;

    logic [7:0] b;
    logic [2:0] major;
    logic [4:0] add;
    logic [1:0] role;
    logic [2:0] want;
    logic       head_fin;
    logic [63:0] hv;
    logic [63:0] shacc;
    logic        is_claim, is_tr, is_mint, ok;
    logic [7:0]  blen;
    logic [3:0]  other;

    assign b = i_item.data_byte;
    assign major = b[7:5];
    assign add = b[4:0];
    assign acct_idx = r_soff[AW-1:0];

    always_comb begin
        n_phase = r_phase; n_entries = r_entries; n_seen = r_seen; n_key = r_key;
        n_acc = r_acc; n_hleft = r_hleft; n_sleft = r_sleft; n_pleft = r_pleft;
        n_pcount = r_pcount; n_soff = r_soff; n_aeq = r_aeq; n_nz = r_nz;
        n_type = r_type; n_amt = r_amt; n_seq = r_seq; n_fee = r_fee;
        n_cur = r_cur; n_ts = r_ts; n_err = r_err;
        acct_we = 1'b0;
        res = '0;
        head_fin = 1'b0;
        hv = '0;
        role = r_phase[1:0];
        shacc = {r_acc[55:0], b};
        want = 3'd0;
        blen = 8'(PUBKEY_BYTES);
        other = (r_key == 4'd2) ? 4'd3 : 4'd2;
        case (r_key)
            4'd2, 4'd3: blen = 8'(ACCOUNT_BYTES);
            4'd10: blen = 8'(ID_BYTES);
            4'd11: blen = 8'(SIGNATURE_BYTES);
            default: blen = 8'(PUBKEY_BYTES);
        endcase
        if (r_err == ERR_NONE) begin
            if (r_phase < PH_ARG) begin
                case (r_phase[1:0])
                    2'd0: want = 3'd5;
                    2'd1: want = 3'd0;
                    2'd3: want = 3'd2;
                    default: begin
                        if (r_key == 4'd7) want = 3'd4;
                        else if (r_key == 4'd2 || r_key == 4'd3 || r_key >= 4'd10) want = 3'd2;
                        else want = 3'd0;
                    end
                endcase
                if (major != want || add > 5'd27) begin
                    n_err = ERR_FORMAT;
                end else if (add < 5'd24) begin
                    head_fin = 1'b1;
                    hv = {59'd0, add};
                end else begin
                    n_hleft = 4'd1 << add[1:0];
                    n_acc = '0;
                    n_phase = r_phase + PH_ARG;
                end
            end else if (r_phase < PH_STRING) begin
                role = r_phase[1:0];
                n_acc = shacc;
                n_hleft = r_hleft - 4'd1;
                if (r_hleft <= 4'd1) begin
                    n_hleft = '0;
                    head_fin = 1'b1;
                    hv = shacc;
                end
            end else if (r_phase == PH_STRING) begin
                res.field_key = r_key;
                res.payload_byte = b;
                res.payload_index = r_soff;
                if ((r_key == 4'd2 || r_key == 4'd3) && r_soff < 8'(ACCOUNT_BYTES)) begin
                    if (r_seen[other]) begin
                        if (r_acct[acct_idx] != b) n_aeq = 1'b0;
                    end else begin
                        acct_we = 1'b1;
                    end
                end
                if (b != 8'd0) begin
                    case (r_key)
                        4'd2: n_nz[0] = 1'b1;
                        4'd3: n_nz[1] = 1'b1;
                        4'd10: n_nz[2] = 1'b1;
                        4'd11: n_nz[3] = 1'b1;
                        4'd12: n_nz[4] = 1'b1;
                        default: ;
                    endcase
                end
                n_soff = r_soff + 8'd1;
                n_sleft = (r_sleft > 8'd0) ? r_sleft - 8'd1 : 8'd0;
                if (n_sleft == 8'd0) begin
                    if (r_key == 4'd7 && r_pleft > 4'd1) begin
                        n_pleft = r_pleft - 4'd1;
                        n_phase = PH_PARENT;
                    end else begin
                        if (r_key == 4'd7) n_pleft = '0;
                        n_entries = (r_entries > 4'd0) ? r_entries - 4'd1 : 4'd0;
                        n_phase = (n_entries == 4'd0) ? PH_TRAIL : PH_KEY;
                    end
                end
            end else begin
                n_err = ERR_FORMAT;
            end

            if (head_fin) begin
                case (role)
                    2'd0: begin
                        if (hv != 64'd11 && hv != 64'd12) n_err = ERR_FORMAT;
                        else begin
                            n_entries = hv[3:0];
                            n_phase = PH_KEY;
                        end
                    end
                    2'd1: begin
                        if (hv == 64'd0 || hv > 64'd12 || r_seen[hv[3:0]]) n_err = ERR_FORMAT;
                        else begin
                            n_seen[hv[3:0]] = 1'b1;
                            n_key = hv[3:0];
                            n_phase = PH_VAL;
                        end
                    end
                    2'd3: begin
                        if (hv != 64'(PARENT_BYTES)) n_err = ERR_SIZE;
                        else begin
                            n_sleft = hv[7:0];
                            n_phase = PH_STRING;
                        end
                    end
                    default: begin
                        if (r_key == 4'd1 || r_key == 4'd4 || r_key == 4'd5 || r_key == 4'd6
                            || r_key == 4'd8 || r_key == 4'd9) begin
                            if (r_key == 4'd1 && hv != {56'd0, i_code_transfer}
                                && hv != {56'd0, i_code_mint} && hv != {56'd0, i_code_claim})
                                n_err = ERR_FORMAT;
                            else if (r_key != 4'd1 && r_key != 4'd8 && hv[63:32] != 32'd0)
                                n_err = ERR_FORMAT;
                            else begin
                                case (r_key)
                                    4'd1: n_type = hv[7:0];
                                    4'd4: n_amt = hv[31:0];
                                    4'd5: n_seq = hv[31:0];
                                    4'd6: n_fee = hv[31:0];
                                    4'd9: n_cur = hv[31:0];
                                    default: n_ts = hv;
                                endcase
                                n_entries = (r_entries > 4'd0) ? r_entries - 4'd1 : 4'd0;
                                n_phase = (n_entries == 4'd0) ? PH_TRAIL : PH_KEY;
                            end
                        end else if (r_key == 4'd7) begin
                            if (hv > 64'(MAX_PARENTS)) n_err = ERR_FORMAT;
                            else begin
                                n_pcount = hv[3:0];
                                n_pleft = hv[3:0];
                                n_soff = '0;
                                if (hv == 64'd0) begin
                                    n_entries = (r_entries > 4'd0) ? r_entries - 4'd1 : 4'd0;
                                    n_phase = (n_entries == 4'd0) ? PH_TRAIL : PH_KEY;
                                end else n_phase = PH_PARENT;
                            end
                        end else begin
                            if (hv != {56'd0, blen}) n_err = ERR_SIZE;
                            else begin
                                n_sleft = hv[7:0];
                                n_soff = '0;
                                n_phase = PH_STRING;
                            end
                        end
                    end
                endcase
            end
        end

        res.parent_total = n_pcount;
        is_claim = (n_type == i_code_claim);
        is_tr = (n_type == i_code_transfer);
        is_mint = (n_type == i_code_mint);
        ok = (n_seen[12:1] & 12'h7FF) == 12'h7FF;
        if (!(is_tr || is_mint || is_claim)) ok = 1'b0;
        if (n_nz[1:0] != 2'b11) ok = 1'b0;
        if (n_amt == 32'd0) ok = 1'b0;
        if (is_tr && n_fee >= n_amt) ok = 1'b0;
        if (is_mint && n_fee != 32'd0) ok = 1'b0;
        if (is_claim) begin
            if (n_fee != 32'd0 || !n_aeq || n_seq != 32'd0 || !n_nz[4]) ok = 1'b0;
        end else if (n_nz[4]) ok = 1'b0;
        if (n_nz[3:2] != 2'b11) ok = 1'b0;
        if (i_item.frame_end) begin
            if (n_err == ERR_NONE) begin
                if (n_phase != PH_TRAIL) n_err = ERR_SIZE;
                else if (!ok) n_err = ERR_FORMAT;
            end
            res.done_res = 1'b1;
            res.tx_type = n_type;
            res.amount = n_amt;
            res.sequence_res = n_seq;
            res.fee = n_fee;
            res.currency = n_cur;
            res.timestamp = n_ts;
        end
        res.status = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (i_step && acct_we) begin
            r_acct[acct_idx] <= b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.frame_end)) begin
            r_phase <= PH_MAP; r_entries <= '0; r_seen <= '0; r_key <= '0;
            r_acc <= '0; r_hleft <= '0; r_sleft <= '0; r_pleft <= '0;
            r_pcount <= '0; r_soff <= '0; r_aeq <= 1'b1; r_nz <= '0;
            r_type <= '0; r_amt <= '0; r_seq <= '0; r_fee <= '0;
            r_cur <= '0; r_ts <= '0; r_err <= ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase; r_entries <= n_entries; r_seen <= n_seen; r_key <= n_key;
            r_acc <= n_acc; r_hleft <= n_hleft; r_sleft <= n_sleft; r_pleft <= n_pleft;
            r_pcount <= n_pcount; r_soff <= n_soff; r_aeq <= n_aeq; r_nz <= n_nz;
            r_type <= n_type; r_amt <= n_amt; r_seq <= n_seq; r_fee <= n_fee;
            r_cur <= n_cur; r_ts <= n_ts; r_err <= n_err;
        end
    end

    assign o_result = res;
endmodule

[rtl/cbor_transaction_decoder.sv]
// Top level of the CBOR transaction decoder.
// The decoder takes one frame byte per cycle unless the output stalls and returns one
// result per byte, registered; each result appears in the cycle after its byte. The
// input is accepted whenever the output register is empty or is being emptied in the
// same cycle. Configuration writes take effect on the next byte.
module cbor_transaction_decoder
    import ctd_pkg::*;
#(
    parameter int ACCOUNT_BYTES = 16,
    parameter int PARENT_BYTES = 32,
    parameter int MAX_PARENTS = 8,
    parameter int ID_BYTES = 32,
    parameter int SIGNATURE_BYTES = 64,
    parameter int PUBKEY_BYTES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ctd_if.sink   i_in,
    ctd_if.sink   i_cfg,
    ctd_if.source o_out
);
    logic [7:0] r_code_transfer, r_code_mint, r_code_claim;
    logic       r_valid;
    t_out_item  r_out;
    t_out_item  result;
    t_in_item   in_item;
    t_cfg_item  cfg_item;
    logic       step;

    assign in_item = i_in.payload;
    assign cfg_item = i_cfg.payload;
    assign i_in.ready = !r_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign step = i_in.valid && i_in.ready;
    assign o_out.valid = r_valid;
    assign o_out.payload = r_out;

    ctd_parser #(
        .ACCOUNT_BYTES(ACCOUNT_BYTES), .PARENT_BYTES(PARENT_BYTES),
        .MAX_PARENTS(MAX_PARENTS), .ID_BYTES(ID_BYTES),
        .SIGNATURE_BYTES(SIGNATURE_BYTES), .PUBKEY_BYTES(PUBKEY_BYTES)
    ) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_item(in_item),
        .i_code_transfer(r_code_transfer), .i_code_mint(r_code_mint),
        .i_code_claim(r_code_claim), .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_transfer <= 8'd0;
            r_code_mint <= 8'd1;
            r_code_claim <= 8'd2;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (cfg_item.index)
                    REG_TRANSFER: r_code_transfer <= cfg_item.data;
                    REG_MINT: r_code_mint <= cfg_item.data;
                    REG_CLAIM: r_code_claim <= cfg_item.data;
                    default: ;
                endcase
            end
            if (step) r_valid <= 1'b1;
            else if (o_out.ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out <= result;
    end
endmodule
